// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/pa3_pkg.sv -----
`default_nettype none

package pa3_pkg;

	// Polygon and coordinate limits.
	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 24;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// Arithmetic widths.
	localparam int SUM_W  = 60;
	localparam int TOL_W  = 32;
	localparam int AREA_W = 60;
	localparam int HALF_W = SUM_W / 2;
	localparam int RAD_W  = 2 * SUM_W;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int ITER_W = $clog2(ROOT_STEPS);

	// Stream widths, padded to whole bytes.
	localparam int IN_W  = ((3 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((AREA_W + 2 + 7) / 8) * 8;

	// Edge queue depth.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FEW   = 2'd1,
		ST_DEGEN = 2'd2,
		ST_MANY  = 2'd3
	} status_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t [2:0] vec_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef sum_t [2:0] sumv_t;

	// One classified vertex as handed from the front to the back.
	typedef struct packed {
		vec_t    prev;
		vec_t    cur;
		vec_t    first;
		logic    edge_en;
		logic    close_en;
		logic    last;
		status_t status;
	} op_t;

	// Closed Newell sums of one polygon, handed to the root unit.
	typedef struct packed {
		logic    valid;
		status_t status;
		sumv_t   sums;
	} fin_t;

	typedef enum logic [2:0] {
		RS_IDLE,
		RS_MAG,
		RS_CHECK,
		RS_SQ,
		RS_ROOT,
		RS_DONE
	} root_state_t;

endpackage

`default_nettype wire

// ----- rtl/pa3_front.sv -----
`default_nettype none

module pa3_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [pa3_pkg::IN_W-1:0]  s_tdata,
	input  wire logic                      s_tlast,
	input  wire logic                      q_full,
	output logic                           op_valid,
	output pa3_pkg::op_t                   op
);
	import pa3_pkg::*;

	vec_t             cur;
	vec_t             first_q;
	vec_t             prev_q;
	logic [CNT_W-1:0] count_q;
	logic             xfer;
	logic             many;

	// Unpack the coordinates of the incoming vertex.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cur[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
		end
	end

	assign s_tready = !q_full;
	assign xfer     = s_tvalid && s_tready;
	assign many     = (count_q == CNT_W'(MAX_POINTS));

	// Classify the vertex: which edges it adds and what status is known already.
	always_comb begin
		op.prev     = prev_q;
		op.cur      = cur;
		op.first    = (count_q == '0) ? cur : first_q;
		op.edge_en  = !many && (count_q != '0);
		op.close_en = s_tlast && !many;
		op.last     = s_tlast;
		if (many) begin
			op.status = ST_MANY;
		end else if (count_q < CNT_W'(2)) begin
			op.status = ST_FEW;
		end else begin
			op.status = ST_OK;
		end
	end

	assign op_valid = xfer && (op.edge_en || s_tlast);

	// Vertex count, saturating at the point limit; cleared by the last vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (xfer) begin
			if (s_tlast) begin
				count_q <= '0;
			end else if (!many) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// First and previous vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			prev_q  <= '0;
		end else if (xfer && !many) begin
			if (count_q == '0) begin
				first_q <= cur;
			end
			prev_q <= cur;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pa3_fifo.sv -----
`default_nettype none

module pa3_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pa3_pkg::op_t  din,
	output logic               full,
	input  wire logic          pop,
	output logic               dout_valid,
	output pa3_pkg::op_t       dout
);
	import pa3_pkg::*;

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign dout_valid = (cnt_q != '0);
	assign dout       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && dout_valid;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pa3_accum.sv -----
`default_nettype none

module pa3_accum (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	input  wire pa3_pkg::op_t  op,
	output logic               pop,
	input  wire logic          root_busy,
	output pa3_pkg::fin_t      fin
);
	import pa3_pkg::*;

	localparam int TERM_W = 2 * (COORD_BITS + 1);

	// Saturating add of one Newell term to a running sum.
	function automatic sum_t sat_add(input sum_t s, input logic signed [TERM_W-1:0] t);
		logic signed [SUM_W:0] r;
		r = (SUM_W+1)'(s) + (SUM_W+1)'(t);
		if (r[SUM_W] != r[SUM_W-1]) begin
			sat_add = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat_add = r[SUM_W-1:0];
		end
	endfunction

	logic                         phase_q;
	logic                         two;
	logic                         sel_close;
	logic                         final_slot;
	logic                         slot_add;
	logic                         slot_fin;
	logic                         fin_block;
	logic                         issue;
	vec_t                         a;
	vec_t                         b;

	logic                         v_s1;
	logic                         add_s1;
	logic                         fin_s1;
	status_t                      st_s1;
	logic signed [COORD_BITS:0]   dif_s1 [3];
	logic signed [COORD_BITS:0]   sm_s1  [3];

	logic                         v_s2;
	logic                         add_s2;
	logic                         fin_s2;
	status_t                      st_s2;
	logic signed [TERM_W-1:0]     prod_s2 [3];

	sum_t                         sum_q [3];
	sum_t                         nxt   [3];
	logic                         fin_v_q;
	status_t                      fin_st_q;
	sumv_t                        fin_sums_q;

	// Slot selection: an op adds the edge from the previous vertex, the
	// closing edge to the first vertex, or both, the edge first and then the closing edge.
	always_comb begin
		two        = op.edge_en && op.close_en;
		sel_close  = two ? phase_q : op.close_en;
		final_slot = !two || phase_q;
		slot_add   = op.edge_en || op.close_en;
		slot_fin   = op.last && final_slot;
		fin_block  = root_busy || fin_v_q || (v_s1 && fin_s1) || (v_s2 && fin_s2);
		issue      = op_valid && (slot_add || slot_fin) && !(slot_fin && fin_block);
		pop        = op_valid && final_slot && !(slot_fin && fin_block);
		a          = sel_close ? op.cur : op.prev;
		b          = sel_close ? op.first : op.cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (op_valid && two && !phase_q) begin
			phase_q <= 1'b1;
		end else if (pop) begin
			phase_q <= 1'b0;
		end
	end

	// Stage 1: coordinate differences and sums of the edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			add_s1 <= 1'b0;
			fin_s1 <= 1'b0;
		end else begin
			v_s1   <= issue;
			add_s1 <= issue && slot_add;
			fin_s1 <= issue && slot_fin;
		end
	end

	always_ff @(posedge clk) begin
		st_s1 <= op.status;
		for (int i = 0; i < 3; i++) begin
			dif_s1[i] <= $signed({a[i][COORD_BITS-1], a[i]})
				- $signed({b[i][COORD_BITS-1], b[i]});
			sm_s1[i]  <= $signed({a[i][COORD_BITS-1], a[i]})
				+ $signed({b[i][COORD_BITS-1], b[i]});
		end
	end

	// Stage 2: the three cross-product terms.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			add_s2 <= 1'b0;
			fin_s2 <= 1'b0;
		end else begin
			v_s2   <= v_s1;
			add_s2 <= add_s1;
			fin_s2 <= fin_s1;
		end
	end

	always_ff @(posedge clk) begin
		st_s2      <= st_s1;
		prod_s2[0] <= dif_s1[1] * sm_s1[2];
		prod_s2[1] <= dif_s1[2] * sm_s1[0];
		prod_s2[2] <= dif_s1[0] * sm_s1[1];
	end

	// Saturating accumulation of the terms.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nxt[i] = add_s2 ? sat_add(sum_q[i], prod_s2[i]) : sum_q[i];
		end
	end

	// Running sums; the polygon's final slot hands them over and clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
			end
			fin_v_q <= 1'b0;
		end else begin
			fin_v_q <= v_s2 && fin_s2;
			if (v_s2) begin
				for (int i = 0; i < 3; i++) begin
					sum_q[i] <= fin_s2 ? '0 : nxt[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && fin_s2) begin
			fin_st_q <= st_s2;
			for (int i = 0; i < 3; i++) begin
				fin_sums_q[i] <= nxt[i];
			end
		end
	end

	// Closed sums as seen by the root unit.
	always_comb begin
		fin.valid  = fin_v_q;
		fin.status = fin_st_q;
		fin.sums   = fin_sums_q;
	end

endmodule

`default_nettype wire

// ----- rtl/pa3_root.sv -----
`default_nettype none

module pa3_root (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pa3_pkg::fin_t              fin,
	input  wire logic [pa3_pkg::TOL_W-1:0]  tol,
	output logic                            busy,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [pa3_pkg::OUT_W-1:0]       m_tdata
);
	import pa3_pkg::*;

	// Partial products of one square, split into 30-bit halves.
	typedef enum logic [1:0] {
		PT_LL,
		PT_HL,
		PT_HH
	} part_t;

	root_state_t             state_q;
	root_state_t             state_d;
	sumv_t                   sn_q;
	status_t                 st_q;
	status_t                 st_fin;
	logic [SUM_W-1:0]        mag_q [3];
	logic                    all_small;

	logic [1:0]              c_q;
	part_t                   p_q;
	logic                    iss_done_q;
	logic [2*HALF_W-1:0]     prod_q;
	part_t                   sh_q;
	logic                    pv_q;
	logic                    plast_q;
	logic [HALF_W-1:0]       op_a;
	logic [HALF_W-1:0]       op_b;
	logic [RAD_W-1:0]        addend;

	logic [RAD_W-1:0]        acc_q;
	logic [REM_W-1:0]        rem_q;
	logic [ROOT_W-1:0]       root_q;
	logic [ITER_W-1:0]       it_q;
	logic [REM_W+1:0]        rem_sh;
	logic [REM_W+1:0]        trial;
	logic                    fits;

	logic                    out_v_q;
	logic [AREA_W-1:0]       area_q;
	status_t                 stat_q;

	logic                    sq_issue;
	logic                    root_step;
	logic                    load_out;

	// Degenerate check against the tolerance.
	always_comb begin
		all_small = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (mag_q[i] > {{(SUM_W-TOL_W){1'b0}}, tol}) begin
				all_small = 1'b0;
			end
		end
		if (st_q != ST_OK) begin
			st_fin = st_q;
		end else if (all_small) begin
			st_fin = ST_DEGEN;
		end else begin
			st_fin = ST_OK;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			RS_IDLE:  if (fin.valid) state_d = RS_MAG;
			RS_MAG:   state_d = RS_CHECK;
			RS_CHECK: state_d = (st_fin != ST_OK) ? RS_DONE : RS_SQ;
			RS_SQ:    if (pv_q && plast_q) state_d = RS_ROOT;
			RS_ROOT:  if (it_q == ITER_W'(ROOT_STEPS - 1)) state_d = RS_DONE;
			RS_DONE:  if (!out_v_q || m_tready) state_d = RS_IDLE;
			default:  state_d = RS_IDLE;
		endcase
	end

	// Controls decoded from the state.
	always_comb begin
		busy      = 1'b1;
		sq_issue  = 1'b0;
		root_step = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			RS_IDLE: busy = 1'b0;
			RS_SQ:   sq_issue = !iss_done_q;
			RS_ROOT: root_step = 1'b1;
			RS_DONE: load_out = !out_v_q || m_tready;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Operand selection for the shared 30x30 multiplier.
	always_comb begin
		case (p_q)
			PT_LL: begin
				op_a = mag_q[c_q][HALF_W-1:0];
				op_b = mag_q[c_q][HALF_W-1:0];
			end
			PT_HL: begin
				op_a = mag_q[c_q][SUM_W-1:HALF_W];
				op_b = mag_q[c_q][HALF_W-1:0];
			end
			PT_HH: begin
				op_a = mag_q[c_q][SUM_W-1:HALF_W];
				op_b = mag_q[c_q][SUM_W-1:HALF_W];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Place a partial product; the cross term counts twice.
	always_comb begin
		case (sh_q)
			PT_LL:   addend = RAD_W'(prod_q);
			PT_HL:   addend = RAD_W'(prod_q) << (HALF_W + 1);
			PT_HH:   addend = RAD_W'(prod_q) << (2 * HALF_W);
			default: addend = '0;
		endcase
	end

	// One restoring square-root step: two radicand bits per cycle.
	always_comb begin
		rem_sh = {rem_q, acc_q[RAD_W-1 -: 2]};
		trial  = (REM_W+2)'({root_q, 2'b01});
		fits   = (rem_sh >= trial);
	end

	// Sequencing registers of the square and root units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q        <= '0;
			p_q        <= PT_LL;
			iss_done_q <= 1'b0;
			pv_q       <= 1'b0;
			plast_q    <= 1'b0;
			it_q       <= '0;
		end else begin
			pv_q <= sq_issue;
			if (state_q == RS_CHECK) begin
				c_q        <= '0;
				p_q        <= PT_LL;
				iss_done_q <= 1'b0;
				it_q       <= '0;
			end else if (sq_issue) begin
				plast_q <= (c_q == 2'd2) && (p_q == PT_HH);
				if (p_q == PT_HH) begin
					p_q <= PT_LL;
					if (c_q == 2'd2) begin
						iss_done_q <= 1'b1;
					end else begin
						c_q <= c_q + 2'd1;
					end
				end else if (p_q == PT_LL) begin
					p_q <= PT_HL;
				end else begin
					p_q <= PT_HH;
				end
			end else if (root_step) begin
				it_q <= it_q + ITER_W'(1);
			end
		end
	end

	// Datapath of the closing computation.
	always_ff @(posedge clk) begin
		if (state_q == RS_IDLE && fin.valid) begin
			sn_q <= fin.sums;
			st_q <= fin.status;
		end
		if (state_q == RS_MAG) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= sn_q[i][SUM_W-1] ? (~sn_q[i] + 1'b1) : sn_q[i];
			end
		end
		if (state_q == RS_CHECK) begin
			st_q   <= st_fin;
			acc_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (sq_issue) begin
			prod_q <= op_a * op_b;
			sh_q   <= p_q;
		end
		if (state_q == RS_SQ && pv_q) begin
			acc_q <= acc_q + addend;
		end
		if (root_step) begin
			acc_q  <= acc_q << 2;
			rem_q  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	// Output register: a finished result waits here for its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			area_q <= (st_q == ST_OK) ? AREA_W'(root_q >> 1) : '0;
			stat_q <= st_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_W'({stat_q, area_q});

endmodule

`default_nettype wire

// ----- rtl/polygon_area_3d_top.sv -----
// Throughput: one vertex per cycle while the four-entry queue is not full; the back end adds
// the edge of each vertex and both edges of a closing vertex in turn, and a polygon closes
// only once the root unit is idle. With an empty queue and an idle root unit, m_tvalid for an
// ok status follows the last vertex transfer after squaring on the shared 30x30 multiplier and
// 60 square-root steps; for an error status it follows without either.
// Reset (arst_n low, asynchronous) clears all polygon state and sets the tolerance tol_q to 7.
`default_nettype none
`include "assert_macros.svh"

module polygon_area_3d_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// vx [23:0], vy [47:24], vz [71:48]
	input  wire logic [pa3_pkg::IN_W-1:0]   s_tdata,
	input  wire logic                       s_tlast,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// area [59:0], status [61:60], zero [63:62]
	output logic [pa3_pkg::OUT_W-1:0]       m_tdata,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [pa3_pkg::TOL_W-1:0]  cfg_data
);
	import pa3_pkg::*;

	logic             q_full;
	logic             push;
	op_t              op_in;
	logic             pop;
	logic             q_valid;
	op_t              op_out;
	logic             root_busy;
	fin_t             fin;
	logic [TOL_W-1:0] tol_q;
	logic [1:0]       out_status;

	// Tolerance register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(7);
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	pa3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.op_valid (push),
		.op       (op_in)
	);

	pa3_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (op_in),
		.full       (q_full),
		.pop        (pop),
		.dout_valid (q_valid),
		.dout       (op_out)
	);

	pa3_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_valid),
		.op        (op_out),
		.pop       (pop),
		.root_busy (root_busy),
		.fin       (fin)
	);

	pa3_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.fin      (fin),
		.tol      (tol_q),
		.busy     (root_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	assign out_status = m_tdata[AREA_W+1:AREA_W];

	// A polygon is handed over only to an idle root unit, which then starts.
	`ASSERT_SAME(a_fin_idle, fin.valid, !root_busy)
	`ASSERT_NEXT(a_fin_start, fin.valid, root_busy)
	// Any error status carries a zero area.
	`ASSERT_SAME(a_err_zero, m_tvalid && (out_status != 2'(ST_OK)), m_tdata[AREA_W-1:0] == '0)

endmodule

`default_nettype wire
